// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL that carries checks.
// No dependencies; the user supplies clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on every rising edge of clk, off while rst is high.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while rst is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bdpc_pkg.sv =====
// Package for the button debounce and press classifier: sizes, register codes,
// reset values and the structs passed between modules. No dependencies.
package bdpc_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int COUNT_BITS  = 16;
  localparam int THR_W       = 16;
  localparam int CMP_W       = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [THR_W-1:0]       DEBOUNCE_RESET   = THR_W'(50);
  localparam logic [THR_W-1:0]       LONG_PRESS_RESET = THR_W'(1000);
  localparam logic [NUM_BUTTONS-1:0] ENABLE_RESET     = '0;

  // Register word index, byte address 4*index
  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_SHORT_EN   = 2'd2,
    REG_LONG_EN    = 2'd3
  } bdpc_reg_t;

  typedef struct packed {
    logic [THR_W-1:0] debounce_ticks;
    logic [THR_W-1:0] long_press_ticks;
  } bdpc_thr_t;

  typedef struct packed {
    bdpc_thr_t              thr;
    logic [NUM_BUTTONS-1:0] short_en;
    logic [NUM_BUTTONS-1:0] long_en;
  } bdpc_cfg_t;

  // Per-button result of one tick
  typedef struct packed {
    logic level;
    logic short_ev;
    logic long_ev;
  } bdpc_evt_t;

endpackage

// ===== hdl/bdpc_regs.sv =====
// Configuration registers behind the APB-style port.
// Depends on bdpc_pkg.
module bdpc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bdpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [bdpc_pkg::DATA_W-1:0]  pwdata,
  output logic [bdpc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output bdpc_pkg::bdpc_cfg_t          cfg
);
  import bdpc_pkg::*;

  logic      wr_en;
  bdpc_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = bdpc_reg_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr.debounce_ticks   <= DEBOUNCE_RESET;
      cfg.thr.long_press_ticks <= LONG_PRESS_RESET;
      cfg.short_en             <= ENABLE_RESET;
      cfg.long_en              <= ENABLE_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_DEBOUNCE:   cfg.thr.debounce_ticks   <= pwdata[THR_W-1:0];
        REG_LONG_PRESS: cfg.thr.long_press_ticks <= pwdata[THR_W-1:0];
        REG_SHORT_EN:   cfg.short_en             <= pwdata[NUM_BUTTONS-1:0];
        REG_LONG_EN:    cfg.long_en              <= pwdata[NUM_BUTTONS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DEBOUNCE:   prdata = DATA_W'(cfg.thr.debounce_ticks);
      REG_LONG_PRESS: prdata = DATA_W'(cfg.thr.long_press_ticks);
      REG_SHORT_EN:   prdata = DATA_W'(cfg.short_en);
      REG_LONG_EN:    prdata = DATA_W'(cfg.long_en);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== hdl/bdpc_button.sv =====
// Per-button debounce and press classification state, advanced one tick per item.
// Depends on bdpc_pkg.
module bdpc_button (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 raw,
  input  bdpc_pkg::bdpc_thr_t  thr,
  output bdpc_pkg::bdpc_evt_t  evt
);
  import bdpc_pkg::*;

  // state
  logic                  previous_raw;
  logic                  stable_level;
  logic [COUNT_BITS-1:0] settle_count;
  logic [COUNT_BITS-1:0] held_count;
  logic                  long_done;

  logic                  stable_level_next;
  logic [COUNT_BITS-1:0] settle_count_next;
  logic [COUNT_BITS-1:0] held_inc;
  logic [COUNT_BITS-1:0] held_count_next;
  logic                  long_done_mid;
  logic                  long_done_next;
  logic                  take;
  logic                  press;
  logic [CMP_W-1:0]      settle_x, held_inc_x, held_next_x, deb_x, lpt_x;

  always_comb begin
    settle_count_next = (raw != previous_raw) ? '0 :
                        (settle_count == COUNT_MAX) ? settle_count : settle_count + 1'b1;
    held_inc          = (held_count == COUNT_MAX) ? held_count : held_count + 1'b1;

    settle_x   = CMP_W'(settle_count_next);
    held_inc_x = CMP_W'(held_inc);
    deb_x      = CMP_W'(thr.debounce_ticks);
    lpt_x      = CMP_W'(thr.long_press_ticks);

    take  = (settle_x > deb_x) && (raw != stable_level);
    press = take & raw;

    stable_level_next = take ? raw : stable_level;
    held_count_next   = press ? '0 : held_inc;
    long_done_mid     = press ? 1'b0 : long_done;
    held_next_x       = CMP_W'(held_count_next);

    evt.level    = stable_level_next;
    evt.short_ev = take & ~raw & (held_inc_x < lpt_x) & ~long_done;
    evt.long_ev  = stable_level_next & ~long_done_mid & (held_next_x >= lpt_x);
    long_done_next = evt.long_ev | long_done_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw <= 1'b0;
      stable_level <= 1'b0;
      settle_count <= '0;
      held_count   <= '0;
      long_done    <= 1'b0;
    end else if (advance) begin
      previous_raw <= raw;
      stable_level <= stable_level_next;
      settle_count <= settle_count_next;
      held_count   <= held_count_next;
      long_done    <= long_done_next;
    end
  end

endmodule

// ===== hdl/button_debounce_press_classifier.sv =====
// Button debounce and press classifier, three active-high buttons, one tick per item.
// Result valid in the cycle after input accept; throughput one item per cycle while
// the consumer keeps up. The result register lies between input accept and result.
// Input is taken whenever the result register is empty or being drained.
// Synchronous active-high reset clears all button state and loads register defaults.
// Depends on bdpc_pkg, bdpc_regs, bdpc_button and assert_macros.svh.
`include "assert_macros.svh"
module button_debounce_press_classifier (
  input  logic                               clk,
  input  logic                               rst,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bdpc_pkg::ADDR_W-1:0]        paddr,
  input  logic [bdpc_pkg::DATA_W-1:0]        pwdata,
  output logic [bdpc_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  // tick items in
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bdpc_pkg::NUM_BUTTONS-1:0]   raw_levels,
  // result items out
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bdpc_pkg::NUM_BUTTONS-1:0]   debounced_levels,
  output logic [bdpc_pkg::NUM_BUTTONS-1:0]   short_press,
  output logic [bdpc_pkg::NUM_BUTTONS-1:0]   long_press
);
  import bdpc_pkg::*;

  bdpc_cfg_t              cfg;
  bdpc_evt_t              evt [NUM_BUTTONS];
  logic                   in_take;
  logic [NUM_BUTTONS-1:0] level_next;
  logic [NUM_BUTTONS-1:0] short_next;
  logic [NUM_BUTTONS-1:0] long_next;

  bdpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The result register frees up in the same cycle it is drained, so
  // an item can enter every cycle while the consumer keeps up.
  assign in_ready = ~out_valid | out_ready;
  assign in_take  = in_valid & in_ready;

  // One state slice per button; state moves only when an item is taken.
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    bdpc_button u_btn (
      .clk     (clk),
      .rst     (rst),
      .advance (in_take),
      .raw     (raw_levels[b]),
      .thr     (cfg.thr),
      .evt     (evt[b])
    );
    assign level_next[b] = evt[b].level;
    assign short_next[b] = evt[b].short_ev;
    assign long_next[b]  = evt[b].long_ev;
  end

  // Result register. Pulses are masked here; state advances regardless.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      debounced_levels <= level_next;
      short_press      <= short_next & cfg.short_en;
      long_press       <= long_next & cfg.long_en;
    end
  end

  // A short press comes only with a release, a long press only while held.
  `ASSERT_IMPL(a_short_released, out_valid, (short_press & debounced_levels) == '0, "short press on held button")
  `ASSERT_IMPL(a_long_held, out_valid, (long_press & ~debounced_levels) == '0, "long press on released button")
  `ASSERT_IMPL(a_no_both, out_valid, (short_press & long_press) == '0, "short and long press together")
  `ASSERT_NEXT(a_result_follows, in_take, out_valid, "accepted item gave no result")

endmodule

// ===== test/bdpc_press_checker.sv =====
`timescale 1ns / 1ps
// Checker for the button debounce and press classifier: follows register traffic,
// predicts every tick result and compares it with the block's output channel.
// Depends on bdpc_pkg.
module bdpc_press_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bdpc_pkg::ADDR_W-1:0]        paddr,
  input  logic [bdpc_pkg::DATA_W-1:0]        pwdata,
  input  logic [bdpc_pkg::DATA_W-1:0]        prdata,
  input  logic                               pready,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [bdpc_pkg::NUM_BUTTONS-1:0]   raw_levels,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [bdpc_pkg::NUM_BUTTONS-1:0]   debounced_levels,
  input  logic [bdpc_pkg::NUM_BUTTONS-1:0]   short_press,
  input  logic [bdpc_pkg::NUM_BUTTONS-1:0]   long_press,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 ticks_checked,
  output int                                 short_pulses,
  output int                                 long_pulses
);
  import bdpc_pkg::*;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] levels;
    logic [NUM_BUTTONS-1:0] shorts;
    logic [NUM_BUTTONS-1:0] longs;
  } tick_result_t;

  // register copies
  logic [THR_W-1:0]       debounce_cfg;
  logic [THR_W-1:0]       long_cfg;
  logic [NUM_BUTTONS-1:0] short_en_cfg;
  logic [NUM_BUTTONS-1:0] long_en_cfg;

  // per-button state
  logic [NUM_BUTTONS-1:0] prev_raw;
  logic [NUM_BUTTONS-1:0] stable;
  logic [NUM_BUTTONS-1:0] long_done;
  logic [COUNT_BITS-1:0]  settle [NUM_BUTTONS];
  logic [COUNT_BITS-1:0]  held   [NUM_BUTTONS];

  tick_result_t expected_ticks [$];
  tick_result_t oldest;
  logic [DATA_W-1:0] reg_now;

  function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic tick_result_t classify_tick(input logic [NUM_BUTTONS-1:0] raw);
    tick_result_t r;
    int b;
    r = '0;
    for (b = 0; b < NUM_BUTTONS; b++) begin
      if (raw[b] != prev_raw[b]) settle[b] = '0;
      else settle[b] = count_up(settle[b]);
      held[b] = count_up(held[b]);
      if (settle[b] > debounce_cfg && raw[b] != stable[b]) begin
        stable[b] = raw[b];
        if (raw[b]) begin
          held[b]      = '0;
          long_done[b] = 1'b0;
        end else if (held[b] < long_cfg && !long_done[b]) begin
          r.shorts[b] = 1'b1;
        end
      end
      if (stable[b] && !long_done[b] && held[b] >= long_cfg) begin
        long_done[b] = 1'b1;
        r.longs[b]   = 1'b1;
      end
      prev_raw[b] = raw[b];
      r.levels[b] = stable[b];
    end
    r.shorts = r.shorts & short_en_cfg;
    r.longs  = r.longs & long_en_cfg;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("MISMATCH %s: got %0h, expected %0h (tick %0d)", what, got, want,
             ticks_checked);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      debounce_cfg  = DEBOUNCE_RESET;
      long_cfg      = LONG_PRESS_RESET;
      short_en_cfg  = ENABLE_RESET;
      long_en_cfg   = ENABLE_RESET;
      prev_raw      = '0;
      stable        = '0;
      long_done     = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        settle[b] = '0;
        held[b]   = '0;
      end
      expected_ticks.delete();
      fail_count    = 0;
      ticks_checked = 0;
      short_pulses  = 0;
      long_pulses   = 0;
    end else begin
      // results first: the one leaving now was predicted on an earlier edge
      if (out_valid && out_ready) begin
        if (expected_ticks.size() == 0) begin
          report_mismatch("result with no tick pending", 32'(debounced_levels), 32'd0);
        end else begin
          oldest = expected_ticks.pop_front();
          if (debounced_levels !== oldest.levels)
            report_mismatch("debounced_levels", 32'(debounced_levels),
                            32'(oldest.levels));
          if (short_press !== oldest.shorts)
            report_mismatch("short_press", 32'(short_press), 32'(oldest.shorts));
          if (long_press !== oldest.longs)
            report_mismatch("long_press", 32'(long_press), 32'(oldest.longs));
          ticks_checked++;
          short_pulses += $countones(oldest.shorts);
          long_pulses  += $countones(oldest.longs);
        end
      end
      if (in_valid && in_ready)
        expected_ticks.push_back(classify_tick(raw_levels));
      if (psel && penable && pready) begin
        case (bdpc_reg_t'(paddr[ADDR_W-1:2]))
          REG_DEBOUNCE:   reg_now = DATA_W'(debounce_cfg);
          REG_LONG_PRESS: reg_now = DATA_W'(long_cfg);
          REG_SHORT_EN:   reg_now = DATA_W'(short_en_cfg);
          default:        reg_now = DATA_W'(long_en_cfg);
        endcase
        if (pwrite) begin
          case (bdpc_reg_t'(paddr[ADDR_W-1:2]))
            REG_DEBOUNCE:   debounce_cfg = pwdata[THR_W-1:0];
            REG_LONG_PRESS: long_cfg     = pwdata[THR_W-1:0];
            REG_SHORT_EN:   short_en_cfg = pwdata[NUM_BUTTONS-1:0];
            default:        long_en_cfg  = pwdata[NUM_BUTTONS-1:0];
          endcase
        end else if (prdata !== reg_now) begin
          report_mismatch("register read-back", prdata, reg_now);
        end
      end
    end
    pending = expected_ticks.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Top of the classifier testbench: clock, reset, register programming, tick stimulus
// and receiver back-pressure. Depends on bdpc_pkg, the block and bdpc_press_checker.
module tb;
  import bdpc_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int PRESSURE_CYCLES = 300;
  localparam int RANDOM_PHASES   = 4;
  localparam int PHASE_TICKS     = 100;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]      pwdata = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [NUM_BUTTONS-1:0] raw_levels = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [NUM_BUTTONS-1:0] debounced_levels;
  logic [NUM_BUTTONS-1:0] short_press;
  logic [NUM_BUTTONS-1:0] long_press;

  int fail_count, pending, ticks_checked, short_pulses, long_pulses;

  // sender shaping
  int                     burst_left   = 0;
  bit                     pressure_req = 1'b0;
  logic [NUM_BUTTONS-1:0] last_raw     = '0;
  int                     deb_now      = 50;
  int                     lng_now      = 1000;
  int                     settings_used = 0;
  int                     cycle_count  = 0;

  always #5 clk = ~clk;

  button_debounce_press_classifier dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .raw_levels       (raw_levels),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .debounced_levels (debounced_levels),
    .short_press      (short_press),
    .long_press       (long_press)
  );

  bdpc_press_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .raw_levels       (raw_levels),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .debounced_levels (debounced_levels),
    .short_press      (short_press),
    .long_press       (long_press),
    .fail_count       (fail_count),
    .pending          (pending),
    .ticks_checked    (ticks_checked),
    .short_pulses     (short_pulses),
    .long_pulses      (long_pulses)
  );

  // Receiver: picks a new stall pattern each time its pattern counter runs out (always
  // ready, coin toss, one in four, mostly ready). A pressure request from the stimulus
  // turns into one long hold-off counted here, so the result register fills and in_ready drops.
  initial begin : receiver
    int stall_left;
    int pattern_left;
    int mode;
    stall_left   = 0;
    pattern_left = 0;
    mode         = 0;
    forever begin
      @(negedge clk);
      if (pattern_left == 0) begin
        mode         = $urandom_range(0, 3);
        pattern_left = 64;
      end
      pattern_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (pressure_req) begin
        pressure_req = 1'b0;
        stall_left   = PRESSURE_CYCLES;
        out_ready   <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= (pattern_left % 4 == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still owed", CYCLE_LIMIT, pending);
    $display("Regression FAIL");
    $finish;
  end

  // One register write followed by a read-back of the same register.
  // Entered and left at a falling edge.
  task automatic write_reg(input bdpc_reg_t idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drops valid, waits for every owed result, then lets the pipeline settle
  // before registers may change.
  task automatic wait_idle();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // New register setting. Junk is put above each field to check the masking.
  task automatic apply_setting(input logic [THR_W-1:0] deb, input logic [THR_W-1:0] lng,
                               input logic [NUM_BUTTONS-1:0] sen,
                               input logic [NUM_BUTTONS-1:0] len);
    logic [DATA_W-1:0] junk;
    wait_idle();
    junk = $urandom();
    write_reg(REG_DEBOUNCE, {junk[DATA_W-1:THR_W], deb});
    junk = $urandom();
    write_reg(REG_LONG_PRESS, {junk[DATA_W-1:THR_W], lng});
    junk = $urandom();
    write_reg(REG_SHORT_EN, {junk[DATA_W-1:NUM_BUTTONS], sen});
    junk = $urandom();
    write_reg(REG_LONG_EN, {junk[DATA_W-1:NUM_BUTTONS], len});
    deb_now = int'(deb);
    lng_now = int'(lng);
    settings_used++;
  endtask

  // Offers one tick item. Gaps open only between bursts; valid stays high
  // across items inside a burst, only the payload moves.
  task automatic send_tick(input logic [NUM_BUTTONS-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    raw_levels <= v;
    last_raw    = v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Random press traffic: mostly clean holds of one button (sometimes a
  // whole new pattern), nearly always long enough to pass the debounce and often the long
  // threshold, the rest random contact bounce up to two ticks past the debounce window.
  task automatic press_traffic(input int ticks);
    int sent;
    int len;
    logic [NUM_BUTTONS-1:0] level;
    sent = 0;
    while (sent < ticks) begin
      if ($urandom_range(0, 9) < 7) begin
        level = last_raw ^ (NUM_BUTTONS'(1) << $urandom_range(0, NUM_BUTTONS - 1));
        if ($urandom_range(0, 4) == 0) level = NUM_BUTTONS'($urandom_range(0, 7));
        len = deb_now + 1 + $urandom_range(0, lng_now + 6);
        repeat (len) send_tick(level);
      end else begin
        len = $urandom_range(1, deb_now + 2);
        repeat (len) send_tick(NUM_BUTTONS'($urandom_range(0, 7)));
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Zero debounce and zero long threshold: long fires on the press tick.
    apply_setting(16'd0, 16'd0, 3'b111, 3'b111);
    send_tick(3'b000);
    send_tick(3'b111);
    send_tick(3'b111);
    send_tick(3'b000);
    send_tick(3'b000);

    // Short releases on buttons 0 and 2 (2 masked), then a long hold on
    // button 1, whose long pulse is enabled; bounce at the end.
    apply_setting(16'd1, 16'd4, 3'b001, 3'b010);
    repeat (3) send_tick(3'b101);
    repeat (3) send_tick(3'b000);
    repeat (8) send_tick(3'b010);
    repeat (3) send_tick(3'b000);
    send_tick(3'b110);
    send_tick(3'b001);
    send_tick(3'b110);

    // Random phases, each with its own small thresholds; masks are random after the first.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) apply_setting(THR_W'($urandom_range(0, 6)), THR_W'($urandom_range(0, 24)),
                                3'b111, 3'b111);
      else apply_setting(THR_W'($urandom_range(0, 6)), THR_W'($urandom_range(0, 24)),
                         NUM_BUTTONS'($urandom_range(0, 7)),
                         NUM_BUTTONS'($urandom_range(0, 7)));
      if (p == 1) pressure_req = 1'b1;
      press_traffic(PHASE_TICKS);
    end

    apply_setting(16'd2, 16'd20, 3'b111, 3'b111);
    press_traffic(40);

    wait_idle();
    repeat (4) @(negedge clk);
    $display("Checked %0d tick items over %0d register settings, bounce and holds.",
             ticks_checked, settings_used);
    $display("Saw %0d short and %0d long pulses; one %0d-cycle receiver hold-off.",
             short_pulses, long_pulses, PRESSURE_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
